// ===== hw/rtl/erie_pkg.sv =====
package erie_pkg;

	localparam int QUEUE_DEPTH = 2;
	localparam int STORE_DEPTH = 256;
	localparam int REG_DEPTH   = 16;

	localparam logic [2:0] CMD_WR_PROG = 3'd0;
	localparam logic [2:0] CMD_WR_DATA = 3'd1;
	localparam logic [2:0] CMD_WR_REG  = 3'd2;
	localparam logic [2:0] CMD_STEP    = 3'd3;
	localparam logic [2:0] CMD_RD_DATA = 3'd4;
	localparam logic [2:0] CMD_RD_REG  = 3'd5;

	localparam logic [3:0] OP_ADD   = 4'd0;
	localparam logic [3:0] OP_SUB   = 4'd1;
	localparam logic [3:0] OP_MUL   = 4'd2;
	localparam logic [3:0] OP_INC   = 4'd3;
	localparam logic [3:0] OP_AND   = 4'd4;
	localparam logic [3:0] OP_OR    = 4'd5;
	localparam logic [3:0] OP_NOT   = 4'd6;
	localparam logic [3:0] OP_XOR   = 4'd7;
	localparam logic [3:0] OP_LOAD  = 4'd8;
	localparam logic [3:0] OP_STORE = 4'd9;
	localparam logic [3:0] OP_JUMP  = 4'd10;
	localparam logic [3:0] OP_BEQZ  = 4'd11;
	localparam logic [3:0] OP_HALT  = 4'd15;

	localparam logic [2:0] CLS_ARITH = 3'd0;
	localparam logic [2:0] CLS_LOGIC = 3'd1;
	localparam logic [2:0] CLS_DATA  = 3'd2;
	localparam logic [2:0] CLS_CTRL  = 3'd3;
	localparam logic [2:0] CLS_HALT  = 3'd4;
	localparam logic [2:0] CLS_NONE  = 3'd5;

	typedef struct packed {
		logic [2:0] command;
		logic [7:0] address;
		logic [7:0] value;
	} item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH_HI,
		ST_FETCH_LO,
		ST_EXEC,
		ST_LOAD,
		ST_RD_DATA,
		ST_RD_REG
	} state_t;

	function automatic logic [2:0] op_class(input logic [3:0] op);
		logic [2:0] cls;
		unique case (op[3:2])
			2'b00: cls = CLS_ARITH;
			2'b01: cls = CLS_LOGIC;
			2'b10: cls = op[1] ? CLS_CTRL : CLS_DATA;
			default: cls = CLS_HALT;
		endcase
		return cls;
	endfunction

endpackage

// ===== hw/rtl/eight_bit_risc_instruction_executor_core.sv =====
// channel | valid     | stall     | payload
// input   | in_valid  | in_stall  | command, address, value
// output  | out_valid | out_stall | read_value, instruction_class, halted, program_counter
//
// Writes, bad commands, register reads past 15 and steps while halted finish from idle
// in the back end; other reads add a read state; steps (load adds a load state) make
// two reads on the program store's one read port, then a register read, then execute.
// A queue of QueueDepth entries takes transfers while the back end is busy.
// Reset clears pc, the halt flag, the queue and the result slot; stores are not cleared.
// out_stall holds the result and stops the back end from starting the next item.
module eight_bit_risc_instruction_executor_core #(
	parameter int QueueDepth = erie_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] command,
	input  logic [7:0] address,
	input  logic [7:0] value,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] read_value,
	output logic [2:0] instruction_class,
	output logic       halted,
	output logic [7:0] program_counter
);

	logic            q_valid, q_pop;
	erie_pkg::item_t q_item;

	erie_front #(.Depth(QueueDepth)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .address(address), .value(value),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop));

	erie_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
		.out_valid(out_valid), .out_stall(out_stall),
		.read_value(read_value), .instruction_class(instruction_class),
		.halted(halted), .program_counter(program_counter));

endmodule

// ===== hw/rtl/erie_ram.sv =====
module erie_ram #(
	parameter int Width = 8,
	parameter int Depth = erie_pkg::STORE_DEPTH
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/erie_front.sv =====
module erie_front #(
	parameter int Depth = erie_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [2:0]          command,
	input  logic [7:0]          address,
	input  logic [7:0]          value,
	output logic                q_valid,
	output erie_pkg::item_t     q_item,
	input  logic                q_pop
);

	localparam int IdxW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	erie_pkg::item_t buf_q [Depth];
	logic [IdxW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            push, pop;

	assign in_stall = (count_q == CntW'(Depth));
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != '0);
	assign pop      = q_pop && q_valid;
	assign q_item   = buf_q[rd_ptr_q];

	function automatic logic [IdxW-1:0] bump(input logic [IdxW-1:0] p);
		return (p == IdxW'(Depth - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= '{command: command, address: address, value: value};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= bump(wr_ptr_q);
			if (pop)  rd_ptr_q <= bump(rd_ptr_q);
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(Depth))
		else $error("queue count beyond depth");

endmodule

// ===== hw/rtl/erie_back.sv =====
module erie_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  erie_pkg::item_t q_item,
	output logic            q_pop,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [7:0]      read_value,
	output logic [2:0]      instruction_class,
	output logic            halted,
	output logic [7:0]      program_counter
);

	erie_pkg::state_t state_q, state_d;
	logic [7:0] pc_q, pc_d;
	logic       stopped_q, stop_d;
	logic [7:0] hi_q, lo_q, lo_w;
	logic       out_valid_q;
	logic [7:0] rd_q, out_pc_q;
	logic [2:0] cls_q;
	logic       out_halt_q;

	logic       done;
	logic [7:0] done_rd;
	logic [2:0] done_cls;
	logic       slot_free;

	logic       pm_we, dm_we, rf_we;
	logic [7:0] pm_raddr, pm_rdata, dm_waddr, dm_wdata, dm_raddr, dm_rdata;
	logic [3:0] rf_waddr, rfa_raddr, rfb_raddr;
	logic [7:0] rf_wdata, rfa_rdata, rfb_rdata;

	logic [3:0]  op, fa, fb, fc;
	logic [15:0] prod;
	logic [7:0]  pc_seq, ea;

	assign slot_free = !out_valid_q || !out_stall;
	assign lo_w      = (state_q == erie_pkg::ST_FETCH_LO) ? pm_rdata : lo_q;
	assign op        = hi_q[7:4];
	assign fa        = hi_q[3:0];
	assign fb        = lo_w[7:4];
	assign fc        = lo_w[3:0];
	assign prod      = {8'd0, rfa_rdata} * {8'd0, rfb_rdata};
	assign pc_seq    = pc_q + 8'd2;
	assign ea        = rfa_rdata + {{4{fc[3]}}, fc};

	erie_ram #(.Width(8), .Depth(erie_pkg::STORE_DEPTH)) u_prog (
		.clk(clk), .we(pm_we), .waddr(q_item.address), .wdata(q_item.value),
		.raddr(pm_raddr), .rdata(pm_rdata));

	erie_ram #(.Width(8), .Depth(erie_pkg::STORE_DEPTH)) u_data (
		.clk(clk), .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata),
		.raddr(dm_raddr), .rdata(dm_rdata));

	// two copies of the register file give two read ports
	erie_ram #(.Width(8), .Depth(erie_pkg::REG_DEPTH)) u_rf_a (
		.clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
		.raddr(rfa_raddr), .rdata(rfa_rdata));

	erie_ram #(.Width(8), .Depth(erie_pkg::REG_DEPTH)) u_rf_b (
		.clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
		.raddr(rfb_raddr), .rdata(rfb_rdata));

	always_comb begin
		state_d   = state_q;
		pc_d      = pc_q;
		stop_d    = stopped_q;
		q_pop     = 1'b0;
		pm_we     = 1'b0;
		dm_we     = 1'b0;
		rf_we     = 1'b0;
		dm_waddr  = q_item.address;
		dm_wdata  = q_item.value;
		rf_waddr  = q_item.address[3:0];
		rf_wdata  = q_item.value;
		pm_raddr  = pc_q;
		dm_raddr  = q_item.address;
		rfa_raddr = q_item.address[3:0];
		rfb_raddr = fc;
		done      = 1'b0;
		done_rd   = 8'd0;
		done_cls  = erie_pkg::CLS_NONE;
		unique case (state_q)
			erie_pkg::ST_IDLE: begin
				if (q_valid && slot_free) begin
					q_pop = 1'b1;
					unique case (q_item.command)
						erie_pkg::CMD_WR_PROG: begin
							pm_we = 1'b1;
							done  = 1'b1;
						end
						erie_pkg::CMD_WR_DATA: begin
							dm_we = 1'b1;
							done  = 1'b1;
						end
						erie_pkg::CMD_WR_REG: begin
							rf_we = (q_item.address[7:4] == 4'd0);
							done  = 1'b1;
						end
						erie_pkg::CMD_STEP: begin
							if (stopped_q) done = 1'b1;
							else state_d = erie_pkg::ST_FETCH_HI;
						end
						erie_pkg::CMD_RD_DATA: state_d = erie_pkg::ST_RD_DATA;
						erie_pkg::CMD_RD_REG: begin
							if (q_item.address[7:4] == 4'd0) state_d = erie_pkg::ST_RD_REG;
							else done = 1'b1;
						end
						default: done = 1'b1;
					endcase
				end
			end
			erie_pkg::ST_FETCH_HI: begin
				pm_raddr = pc_q + 8'd1;
				state_d  = erie_pkg::ST_FETCH_LO;
			end
			erie_pkg::ST_FETCH_LO: begin
				rfa_raddr = (op == erie_pkg::OP_INC || op == erie_pkg::OP_BEQZ) ? fa : fb;
				rfb_raddr = (op == erie_pkg::OP_STORE) ? fa : fc;
				state_d   = erie_pkg::ST_EXEC;
			end
			erie_pkg::ST_EXEC: begin
				done     = 1'b1;
				done_cls = erie_pkg::op_class(op);
				pc_d     = pc_seq;
				state_d  = erie_pkg::ST_IDLE;
				rf_waddr = fa;
				rf_we    = (op[3] == 1'b0);
				unique case (op)
					erie_pkg::OP_ADD: rf_wdata = rfa_rdata + rfb_rdata;
					erie_pkg::OP_SUB: rf_wdata = rfa_rdata - rfb_rdata;
					erie_pkg::OP_MUL: rf_wdata = prod[7:0];
					erie_pkg::OP_INC: rf_wdata = rfa_rdata + 8'd1;
					erie_pkg::OP_AND: rf_wdata = rfa_rdata & rfb_rdata;
					erie_pkg::OP_OR:  rf_wdata = rfa_rdata | rfb_rdata;
					erie_pkg::OP_NOT: rf_wdata = ~rfa_rdata;
					erie_pkg::OP_XOR: rf_wdata = rfa_rdata ^ rfb_rdata;
					erie_pkg::OP_LOAD: begin
						dm_raddr = ea;
						done     = 1'b0;
						pc_d     = pc_q;
						state_d  = erie_pkg::ST_LOAD;
					end
					erie_pkg::OP_STORE: begin
						dm_we    = 1'b1;
						dm_waddr = ea;
						dm_wdata = rfb_rdata;
					end
					// offsets count instructions, so they are doubled
					erie_pkg::OP_JUMP: pc_d = pc_seq + {fa[2:0], fb, 1'b0};
					erie_pkg::OP_BEQZ: begin
						if (rfa_rdata == 8'd0) pc_d = pc_seq + {fb[2:0], fc, 1'b0};
					end
					default: begin
						if (op == erie_pkg::OP_HALT) stop_d = 1'b1;
					end
				endcase
			end
			erie_pkg::ST_LOAD: begin
				rf_we    = 1'b1;
				rf_waddr = fa;
				rf_wdata = dm_rdata;
				done     = 1'b1;
				done_cls = erie_pkg::CLS_DATA;
				pc_d     = pc_seq;
				state_d  = erie_pkg::ST_IDLE;
			end
			erie_pkg::ST_RD_DATA: begin
				done    = 1'b1;
				done_rd = dm_rdata;
				state_d = erie_pkg::ST_IDLE;
			end
			erie_pkg::ST_RD_REG: begin
				done    = 1'b1;
				done_rd = rfa_rdata;
				state_d = erie_pkg::ST_IDLE;
			end
			default: state_d = erie_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == erie_pkg::ST_FETCH_HI) hi_q <= pm_rdata;
		if (state_q == erie_pkg::ST_FETCH_LO) lo_q <= pm_rdata;
		if (done) begin
			rd_q       <= done_rd;
			cls_q      <= done_cls;
			out_pc_q   <= pc_d;
			out_halt_q <= stop_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= erie_pkg::ST_IDLE;
			pc_q        <= 8'd0;
			stopped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			pc_q      <= pc_d;
			stopped_q <= stop_d;
			if (done) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign out_valid         = out_valid_q;
	assign read_value        = rd_q;
	assign instruction_class = cls_q;
	assign halted            = out_halt_q;
	assign program_counter   = out_pc_q;

	a_slot_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != erie_pkg::ST_IDLE) |-> !out_valid_q)
		else $error("result slot busy while an item is in flight");

	a_stop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(stopped_q))
		else $error("stopped flag cleared outside reset");

	a_fetch_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == erie_pkg::ST_FETCH_HI) |=> (state_q == erie_pkg::ST_FETCH_LO))
		else $error("fetch sequence broken");

endmodule
